// ===== rtl/core/nce_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the nested call expression evaluator
// no dependencies; used by nce_op_stack and nested_call_expression_evaluator_top
package nce_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	// characters dropped after an operator letter
	localparam logic [1:0] SKIP_AFTER_OP = 2'd2;

	typedef enum logic [1:0] {
		OP_ABS = 2'd0,
		OP_SUB = 2'd1,
		OP_MIN = 2'd2
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic     push;
		logic     pop;
		logic     clear;
		op_code_t code;
	} op_stack_req_t;

	typedef struct packed {
		op_code_t top;
		logic     empty;
		logic     full;
	} op_stack_sts_t;

endpackage

// ===== rtl/core/nce_op_stack.sv =====
`timescale 1ns / 1ps
// operator stack: top entry in a register, the rest in a memory with a
// registered prefetch of the entry below the top; depends on nce_pkg
module nce_op_stack #(
	parameter int STACK_DEPTH = nce_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nce_pkg::op_stack_req_t req,
	output nce_pkg::op_stack_sts_t sts
);
	import nce_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_cnt;
	logic [CW-1:0] rd_cnt;
	op_code_t      top_q;
	op_code_t      below_q;
	op_code_t      mem [STACK_DEPTH];
	logic          full;
	logic          empty;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(STACK_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = req.push && !full;
	assign do_pop  = req.pop && !empty;

	always_comb begin
		n_cnt = cnt_q;
		if (req.clear) begin
			n_cnt = '0;
		end else if (do_push) begin
			n_cnt = cnt_q + CW'(1);
		end else if (do_pop) begin
			n_cnt = cnt_q - CW'(1);
		end
	end

	// prefetch the entry that sits below the next top
	assign rd_cnt = n_cnt - CW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= n_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[cnt_q[AW-1:0]] <= req.code;
			top_q <= req.code;
		end else if (do_pop) begin
			top_q <= below_q;
		end
		below_q <= mem[rd_cnt[AW-1:0]];
	end

	assign sts.top   = top_q;
	assign sts.empty = empty;
	assign sts.full  = full;

endmodule

// ===== rtl/core/nested_call_expression_evaluator_top.sv =====
`timescale 1ns / 1ps
// nested call expression evaluator: character parser, operand stack and result
// register; depends on nce_pkg and nce_op_stack
//
// Usage:
//   Input channel (in_valid/in_ready): one ASCII character per request in
//   char_code, with last_char set on the final character of an expression.
//   Output channel (out_valid/out_ready): one request per expression, carrying
//   result_value (top operand) and status (0 ok, 1 underflow/empty, 2 overflow).
//   Each character is fully processed in the cycle it is accepted; the result
//   appears in the output register in the cycle after the last character is taken.
//   Throughput is one character per cycle while in_ready is high; the operator stack
//   keeps its top entry in a register and the operand stack its top two, and each
//   prefetches the next entry below from a memory read registered every cycle.
//   A new character is taken while a result waits, as long as the output
//   register is empty or being drained in the same cycle; when the receiver
//   holds out_ready low with a result pending, in_ready drops until it is taken.
//   Reset clears all counts, the number parser, skip count and error code; the
//   stack memories are not cleared. After each last character the evaluator
//   returns to that same state for the next expression.
module nested_call_expression_evaluator_top #(
	parameter int STACK_DEPTH = nce_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);
	import nce_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// control state
	logic [CW-1:0] cnt_q;
	logic [1:0]    skip_q;
	logic          num_in_q;
	logic          num_neg_q;
	logic          num_run_q;
	status_t       err_q;
	logic          out_valid_q;

	// payload state
	logic [31:0]   acc_q;
	logic [31:0]   t0_q;
	logic [31:0]   t1_q;
	logic [31:0]   t2_q;
	logic [31:0]   mem [STACK_DEPTH];
	logic [31:0]   res_q;
	status_t       status_q;

	op_stack_req_t op_req;
	op_stack_sts_t op_sts;

	logic          in_acc;
	logic          skip_act;
	logic          is_digit;
	logic          is_minus;
	logic          num_chr;
	logic          other_chr;
	logic          is_letter;
	logic          is_close;
	op_code_t      letter_code;
	logic [31:0]   digit_val;

	logic [1:0]    n_skip;
	logic [31:0]   n_acc;
	logic          n_in;
	logic          n_neg;
	logic          n_run;

	logic          push1;
	logic          push1_ok;
	logic          push1_fail;
	logic [31:0]   v1;
	logic [CW-1:0] cnt1;
	logic [31:0]   e0;
	logic [31:0]   e1;
	logic [31:0]   e2;
	logic          apply_nop;
	logic          apply_pop;
	logic          apply_bin;
	logic          apply_short;
	logic          apply_ok;
	logic [31:0]   abs_v;
	logic [31:0]   bin_v;
	logic          opush_fail;
	status_t       n_err;

	logic [CW-1:0] n_cnt;
	logic [31:0]   n_t0;
	logic [31:0]   n_t1;
	logic          wr_en;
	logic [CW-1:0] wr_cnt;
	logic [31:0]   wr_data;
	logic [CW-1:0] rd_base;
	logic [CW-1:0] rd_cnt;

	logic          push2;
	logic          push2_ok;
	logic [31:0]   v2;
	logic [CW-1:0] cnt_f;
	logic [31:0]   top_f;
	status_t       err_f;
	logic [31:0]   fin_value;
	status_t       fin_status;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// character classes
	always_comb begin
		skip_act  = (skip_q != 2'd0);
		is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
		is_minus  = (char_code == CH_MINUS);
		num_chr   = !skip_act && (is_digit || is_minus);
		other_chr = !skip_act && !is_digit && !is_minus;
		is_close  = other_chr && (char_code == CH_RPAREN);
		is_letter = other_chr &&
			((char_code == CH_M) || (char_code == CH_S) || (char_code == CH_A));
		case (char_code)
			CH_M:    letter_code = OP_MIN;
			CH_S:    letter_code = OP_SUB;
			default: letter_code = OP_ABS;
		endcase
		digit_val = {24'd0, char_code - CH_0};
	end

	// number parser and skip counter
	always_comb begin
		n_skip = skip_q;
		n_acc  = acc_q;
		n_in   = num_in_q;
		n_neg  = num_neg_q;
		n_run  = num_run_q;
		if (skip_act) begin
			n_skip = skip_q - 2'd1;
		end else if (num_chr) begin
			if (!num_in_q) begin
				n_in  = 1'b1;
				n_run = 1'b1;
				n_neg = is_minus;
				n_acc = is_minus ? 32'd0 : digit_val;
			end else if (is_minus) begin
				n_run = 1'b0;
			end else if (num_run_q) begin
				n_acc = (acc_q << 3) + (acc_q << 1) + digit_val;
			end
		end else begin
			n_acc = '0;
			n_in  = 1'b0;
			n_neg = 1'b0;
			n_run = 1'b0;
			if (is_letter) begin
				n_skip = SKIP_AFTER_OP;
			end
		end
	end

	// operand stack: number push, then ')' on the stack tops
	always_comb begin
		push1      = other_chr && num_in_q;
		v1         = num_neg_q ? (32'd0 - acc_q) : acc_q;
		push1_ok   = push1 && (cnt_q != CW'(STACK_DEPTH));
		push1_fail = push1 && (cnt_q == CW'(STACK_DEPTH));
		cnt1       = cnt_q + CW'(push1_ok);
		e0         = push1_ok ? v1 : t0_q;
		e1         = push1_ok ? t0_q : t1_q;
		e2         = push1_ok ? t1_q : t2_q;

		apply_nop   = is_close && op_sts.empty;
		apply_pop   = is_close && !op_sts.empty;
		apply_bin   = (op_sts.top != OP_ABS);
		apply_short = apply_pop && ((cnt1 == '0) || (apply_bin && (cnt1 == CW'(1))));
		apply_ok    = apply_pop && !apply_short;
		abs_v       = e0[31] ? (32'd0 - e0) : e0;
		if (op_sts.top == OP_SUB) begin
			bin_v = e1 - e0;
		end else begin
			bin_v = ($signed(e1) < $signed(e0)) ? e1 : e0;
		end

		opush_fail = is_letter && op_sts.full;

		n_err = err_q;
		if (err_q == ST_OK) begin
			if (push1_fail || opush_fail) begin
				n_err = ST_OVERFLOW;
			end else if (apply_nop || apply_short) begin
				n_err = ST_UNDERFLOW;
			end
		end

		n_cnt   = cnt1;
		n_t0    = e0;
		n_t1    = e1;
		wr_en   = push1_ok;
		wr_cnt  = cnt_q;
		wr_data = v1;
		if (apply_ok) begin
			wr_en = 1'b1;
			if (apply_bin) begin
				n_cnt   = cnt1 - CW'(1);
				n_t0    = bin_v;
				n_t1    = e2;
				wr_cnt  = cnt1 - CW'(2);
				wr_data = bin_v;
			end else begin
				n_t0    = abs_v;
				wr_cnt  = cnt1 - CW'(1);
				wr_data = abs_v;
			end
		end
	end

	// end of expression: pending number and the result
	always_comb begin
		push2    = last_char && n_in;
		v2       = n_neg ? (32'd0 - n_acc) : n_acc;
		push2_ok = push2 && (n_cnt != CW'(STACK_DEPTH));
		cnt_f    = n_cnt + CW'(push2_ok);
		top_f    = push2_ok ? v2 : n_t0;
		err_f    = n_err;
		if (n_err == ST_OK && push2 && !push2_ok) begin
			err_f = ST_OVERFLOW;
		end
		if (cnt_f != '0) begin
			fin_value  = top_f;
			fin_status = err_f;
		end else begin
			fin_value  = '0;
			fin_status = (err_f == ST_OK) ? ST_UNDERFLOW : err_f;
		end
	end

	// prefetch the third entry from the top for the next character
	always_comb begin
		if (!in_acc) begin
			rd_base = cnt_q;
		end else if (last_char) begin
			rd_base = '0;
		end else begin
			rd_base = n_cnt;
		end
		rd_cnt = rd_base - CW'(3);
	end

	always_comb begin
		op_req.push  = in_acc && is_letter;
		op_req.pop   = in_acc && apply_pop;
		op_req.clear = in_acc && last_char;
		op_req.code  = letter_code;
	end

	nce_op_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_op_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (op_req),
		.sts   (op_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			skip_q    <= '0;
			num_in_q  <= 1'b0;
			num_neg_q <= 1'b0;
			num_run_q <= 1'b0;
			acc_q     <= '0;
			err_q     <= ST_OK;
		end else if (in_acc) begin
			if (last_char) begin
				cnt_q     <= '0;
				skip_q    <= '0;
				num_in_q  <= 1'b0;
				num_neg_q <= 1'b0;
				num_run_q <= 1'b0;
				acc_q     <= '0;
				err_q     <= ST_OK;
			end else begin
				cnt_q     <= n_cnt;
				skip_q    <= n_skip;
				num_in_q  <= n_in;
				num_neg_q <= n_neg;
				num_run_q <= n_run;
				acc_q     <= n_acc;
				err_q     <= n_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			t0_q <= n_t0;
			t1_q <= n_t1;
		end
		if (in_acc && wr_en) begin
			mem[wr_cnt[AW-1:0]] <= wr_data;
		end
		t2_q <= mem[rd_cnt[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_char) begin
			res_q    <= fin_value;
			status_q <= fin_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = $signed(res_q);
	assign status       = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("operand count beyond stack depth");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q <= SKIP_AFTER_OP)
		else $error("skip count out of range");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_char) |=> (cnt_q == '0 && err_q == ST_OK && !num_in_q
			&& op_sts.empty))
		else $error("state not cleared after end of expression");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_acc && last_char))
		else $error("result without a final character");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !in_ready)
		else $error("request taken while result register is blocked");

endmodule
